// ----- src/tsd_pkg.sv -----
`default_nettype none

package tsd_pkg;

  // Item kinds carried in the kind field of an input transfer.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_SORT  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CYCLE    = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_NO_SORT  = 2'd3;

  // Depth field width and its saturation value.
  localparam int unsigned DEPTH_W = 10;
  localparam logic [DEPTH_W-1:0] DEPTH_CAP = 10'd1023;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] from_node;
    logic [9:0] to_node;
    logic [9:0] position;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  node_index;
    logic [9:0]  depth;
    logic [10:0] sorted_count;
  } out_t;

endpackage

`default_nettype wire

// ----- src/topological_sort_with_depth_core.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_t: kind, from_node, to_node, position
// out_      output     out_valid / out_ready out_t: status, node_index, depth, sorted_count
// cfg_      input      cfg_we (no wait)      cfg_wdata: nodes in use
//
// An edge load updates the source node, then the target node; a read looks
// up the order memory, then the node memory; a rejected item goes straight
// to the response state, which hands results to the output register. A sort
// seeds the node memory, then pops each ordered node and walks its out-list.
// After reset, and for every clear item, a clearing pass writes every entry
// of the node memory, one a cycle; no input is taken. Items are taken one at
// a time; a waiting result holds the block in its response state until the
// output register is free.
module topological_sort_with_depth_core
  import tsd_pkg::*;
#(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata
);

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic               hv;
    logic [EW-1:0]      head;
    logic [EW-1:0]      tail;
    logic [ECW-1:0]     indeg;
    logic [ECW-1:0]     work;
    logic [DEPTH_W-1:0] depth;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_A_RD, S_A_UPD, S_A_DRD, S_A_DUPD,
    S_T_RD, S_T_WR, S_I_RUN, S_P_RD, S_P_NRD, S_P_NCHK,
    S_E_RD, S_E_CHK, S_E_UPD, S_E_ADV, S_R_QRD, S_R_NRD, S_R_OUT, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  in_t                item_r, item_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic               pend_r, pend_nxt;
  logic [NW-1:0]      pi_r, pi_nxt;
  logic [CW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      tail_r, tail_nxt;
  logic [EW-1:0]      e_r, e_nxt;
  logic [EW-1:0]      tailu_r, tailu_nxt;
  logic [DEPTH_W-1:0] du_r, du_nxt;
  logic [ECW-1:0]     steps_r, steps_nxt;
  logic [NW-1:0]      v_r, v_nxt;
  logic [EW-1:0]      nxt_r, nxt_nxt;
  logic [ECW-1:0]     ecount_r, ecount_nxt;
  logic [CW-1:0]      ordered_r, ordered_nxt;
  logic               sort_valid_r, sort_valid_nxt;
  logic [10:0]        nodes_used_r, nodes_used_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [NW-1:0]      res_idx_r, res_idx_nxt;
  logic [DEPTH_W-1:0] res_dep_r, res_dep_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  // Memory ports.
  logic          node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  node_t         node_wdata, node_rdata;
  logic [NODE_W-1:0] node_rvec;
  logic          q_we;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
  logic          tgt_we;
  logic [EW-1:0] tgt_waddr, edge_raddr;
  logic [NW-1:0] tgt_wdata, tgt_rdata;
  logic          enx_we;
  logic [EW-1:0] enx_waddr, enx_wdata, enx_rdata;

  logic [CW-1:0]      n_act;
  node_t              nw;
  logic [DEPTH_W-1:0] d_new;
  logic [31:0]        idx_wide;

  assign node_rdata = node_t'(node_rvec);

  tsd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rvec)
  );

  tsd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  tsd_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_target_ram (
    .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
    .raddr(edge_raddr), .rdata(tgt_rdata)
  );

  tsd_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next_ram (
    .clk(clk), .we(enx_we), .waddr(enx_waddr), .wdata(enx_wdata),
    .raddr(edge_raddr), .rdata(enx_rdata)
  );

  // Node count in use, limited to the node memory depth.
  always_comb begin
    if (32'(nodes_used_r) > MAX_NODES) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(nodes_used_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: every read, modify and write of the memories.
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    i_nxt          = i_r;
    pend_nxt       = pend_r;
    pi_nxt         = pi_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    e_nxt          = e_r;
    tailu_nxt      = tailu_r;
    du_nxt         = du_r;
    steps_nxt      = steps_r;
    v_nxt          = v_r;
    nxt_nxt        = nxt_r;
    ecount_nxt     = ecount_r;
    ordered_nxt    = ordered_r;
    sort_valid_nxt = sort_valid_r;
    nodes_used_nxt = nodes_used_r;
    clr_resp_nxt   = clr_resp_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_dep_nxt    = res_dep_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    q_we       = 1'b0;
    q_waddr    = '0;
    q_wdata    = '0;
    q_raddr    = '0;
    tgt_we     = 1'b0;
    tgt_waddr  = '0;
    tgt_wdata  = '0;
    enx_we     = 1'b0;
    enx_waddr  = '0;
    enx_wdata  = '0;
    edge_raddr = '0;
    nw         = node_rdata;
    d_new      = '0;
    idx_wide   = '0;

    if (cfg_we) begin
      nodes_used_nxt = cfg_wdata;
    end

    // The output register empties on a result transfer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Clearing pass over the node memory.
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = NW'(i_r);
        node_wdata = '0;
        i_nxt      = i_r + 1'b1;
        if (32'(i_r) == MAX_NODES - 1) begin
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_dep_nxt    = '0;
          state_nxt      = clr_resp_r ? S_RESP : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_dep_nxt    = '0;
          case (in_data.kind)
            KIND_ADD: begin
              if (32'(in_data.from_node) >= 32'(n_act) ||
                  32'(in_data.to_node) >= 32'(n_act) ||
                  32'(ecount_r) >= MAX_EDGES) begin
                res_status_nxt = ST_REJECTED;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_A_RD;
              end
            end
            KIND_SORT: begin
              if (n_act == '0) begin
                ordered_nxt    = '0;
                sort_valid_nxt = 1'b1;
                state_nxt      = S_RESP;
              end else if (32'(n_act) == 1) begin
                state_nxt = S_T_RD;
              end else begin
                i_nxt     = '0;
                pend_nxt  = 1'b0;
                tail_nxt  = '0;
                state_nxt = S_I_RUN;
              end
            end
            KIND_READ: begin
              if (sort_valid_r && 32'(in_data.position) < 32'(ordered_r) &&
                  32'(in_data.position) < MAX_NODES) begin
                state_nxt = S_R_QRD;
              end else begin
                res_status_nxt = ST_NO_SORT;
                state_nxt      = S_RESP;
              end
            end
            default: begin
              ecount_nxt     = '0;
              ordered_nxt    = '0;
              sort_valid_nxt = 1'b0;
              clr_resp_nxt   = 1'b1;
              i_nxt          = '0;
              state_nxt      = S_CLR;
            end
          endcase
        end
      end

      // Edge load: append to the source list, then raise the target count.
      S_A_RD: begin
        node_raddr = NW'(item_r.from_node);
        state_nxt  = S_A_UPD;
      end

      S_A_UPD: begin
        if (node_rdata.hv) begin
          enx_we    = 1'b1;
          enx_waddr = node_rdata.tail;
          enx_wdata = EW'(ecount_r);
        end else begin
          nw.head = EW'(ecount_r);
          nw.hv   = 1'b1;
        end
        nw.tail    = EW'(ecount_r);
        node_we    = 1'b1;
        node_waddr = NW'(item_r.from_node);
        node_wdata = nw;
        tgt_we     = 1'b1;
        tgt_waddr  = EW'(ecount_r);
        tgt_wdata  = NW'(item_r.to_node);
        state_nxt  = S_A_DRD;
      end

      S_A_DRD: begin
        node_raddr = NW'(item_r.to_node);
        state_nxt  = S_A_DUPD;
      end

      S_A_DUPD: begin
        nw.indeg       = node_rdata.indeg + 1'b1;
        node_we        = 1'b1;
        node_waddr     = NW'(item_r.to_node);
        node_wdata     = nw;
        ecount_nxt     = ecount_r + 1'b1;
        sort_valid_nxt = 1'b0;
        state_nxt      = S_RESP;
      end

      // Single-node graph: identity order.
      S_T_RD: begin
        node_raddr = '0;
        state_nxt  = S_T_WR;
      end

      S_T_WR: begin
        nw.depth       = '0;
        node_we        = 1'b1;
        node_waddr     = '0;
        node_wdata     = nw;
        q_we           = 1'b1;
        q_waddr        = '0;
        q_wdata        = '0;
        ordered_nxt    = CW'(1);
        sort_valid_nxt = 1'b1;
        state_nxt      = S_RESP;
      end

      // Seeding: copy counts, zero depths, queue the free nodes in order.
      S_I_RUN: begin
        if (pend_r) begin
          nw.work    = node_rdata.indeg;
          nw.depth   = '0;
          node_we    = 1'b1;
          node_waddr = pi_r;
          node_wdata = nw;
          if (node_rdata.indeg == '0) begin
            q_we     = 1'b1;
            q_waddr  = NW'(tail_r);
            q_wdata  = pi_r;
            tail_nxt = tail_r + 1'b1;
          end
        end
        if (i_r < n_act) begin
          node_raddr = NW'(i_r);
          pend_nxt   = 1'b1;
          pi_nxt     = NW'(i_r);
          i_nxt      = i_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            head_nxt  = '0;
            state_nxt = S_P_RD;
          end
        end
      end

      // Pop the next queued node, or finish the sort.
      S_P_RD: begin
        if (head_r < tail_r) begin
          q_raddr   = NW'(head_r);
          state_nxt = S_P_NRD;
        end else begin
          ordered_nxt    = head_r;
          sort_valid_nxt = (head_r >= n_act);
          res_status_nxt = (head_r >= n_act) ? ST_OK : ST_CYCLE;
          state_nxt      = S_RESP;
        end
      end

      S_P_NRD: begin
        node_raddr = q_rdata;
        head_nxt   = head_r + 1'b1;
        state_nxt  = S_P_NCHK;
      end

      S_P_NCHK: begin
        e_nxt     = node_rdata.head;
        tailu_nxt = node_rdata.tail;
        du_nxt    = node_rdata.depth;
        steps_nxt = '0;
        if (node_rdata.hv && 32'(node_rdata.head) < MAX_EDGES) begin
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_P_RD;
        end
      end

      // Walk the out-list of the popped node.
      S_E_RD: begin
        edge_raddr = e_r;
        state_nxt  = S_E_CHK;
      end

      S_E_CHK: begin
        v_nxt   = tgt_rdata;
        nxt_nxt = enx_rdata;
        if (32'(tgt_rdata) < 32'(n_act)) begin
          node_raddr = tgt_rdata;
          state_nxt  = S_E_UPD;
        end else begin
          state_nxt = S_E_ADV;
        end
      end

      S_E_UPD: begin
        d_new = (du_r >= DEPTH_CAP) ? DEPTH_CAP : du_r + 1'b1;
        if (d_new > node_rdata.depth) begin
          nw.depth = d_new;
        end
        if (node_rdata.work != '0) begin
          nw.work = node_rdata.work - 1'b1;
          if (nw.work == '0 && tail_r < n_act) begin
            q_we     = 1'b1;
            q_waddr  = NW'(tail_r);
            q_wdata  = v_r;
            tail_nxt = tail_r + 1'b1;
          end
        end
        node_we    = 1'b1;
        node_waddr = v_r;
        node_wdata = nw;
        state_nxt  = S_E_ADV;
      end

      S_E_ADV: begin
        steps_nxt = steps_r + 1'b1;
        e_nxt     = nxt_r;
        if (e_r == tailu_r) begin
          state_nxt = S_P_RD;
        end else if (32'(steps_r) + 1 < 32'(ecount_r) && 32'(nxt_r) < MAX_EDGES) begin
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_P_RD;
        end
      end

      // Read of an order position.
      S_R_QRD: begin
        q_raddr   = NW'(item_r.position);
        state_nxt = S_R_NRD;
      end

      S_R_NRD: begin
        node_raddr  = q_rdata;
        res_idx_nxt = q_rdata;
        state_nxt   = S_R_OUT;
      end

      S_R_OUT: begin
        res_dep_nxt = node_rdata.depth;
        state_nxt   = S_RESP;
      end

      // Hand the result over once the output register is free.
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          idx_wide                  = 32'(res_idx_r);
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.node_index   = idx_wide[9:0];
          out_data_nxt.depth        = res_dep_r;
          out_data_nxt.sorted_count = 11'(ordered_r);
          clr_resp_nxt              = 1'b0;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      i_r          <= '0;
      pend_r       <= 1'b0;
      ecount_r     <= '0;
      ordered_r    <= '0;
      sort_valid_r <= 1'b0;
      nodes_used_r <= '0;
      clr_resp_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      pend_r       <= pend_nxt;
      ecount_r     <= ecount_nxt;
      ordered_r    <= ordered_nxt;
      sort_valid_r <= sort_valid_nxt;
      nodes_used_r <= nodes_used_nxt;
      clr_resp_r   <= clr_resp_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    pi_r         <= pi_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    e_r          <= e_nxt;
    tailu_r      <= tailu_nxt;
    du_r         <= du_nxt;
    steps_r      <= steps_nxt;
    v_r          <= v_nxt;
    nxt_r        <= nxt_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_dep_r    <= res_dep_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- src/tsd_ram.sv -----
`default_nettype none

// Simple dual-port synchronous memory: one write port, one read port with
// the read data registered.
module tsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/tsd_checker.sv -----
`default_nettype none

module tsd_checker
  import tsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire in_t         in_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_t        out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting input transfer keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // One item at a time: a transfer in closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a transfer");

  // Only a successful read carries node and depth values.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.node_index == '0 &&
      out_data.depth == '0)
    else $error("non-zero fields on a failed item");

endmodule

bind topological_sort_with_depth_core tsd_checker u_tsd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

`default_nettype wire

// ----- tb/sv/topological_sort_with_depth_core_test.sv -----
`timescale 1ns / 100ps

module topological_sort_with_depth_core_test;
  import tsd_pkg::*;

  localparam int unsigned NODE_SLOTS = 1024;
  localparam int unsigned EDGE_SLOTS = 4096;
  localparam int unsigned SETTLE_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  topological_sort_with_depth_core #(
    .MAX_NODES(NODE_SLOTS),
    .MAX_EDGES(EDGE_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Graph mirror used to work out each expected result.
  logic [9:0]  edge_target [EDGE_SLOTS];
  logic [11:0] edge_next [EDGE_SLOTS];
  logic [11:0] list_head [NODE_SLOTS];
  logic [11:0] list_tail [NODE_SLOTS];
  bit          head_valid [NODE_SLOTS];
  int unsigned in_degree [NODE_SLOTS];
  int unsigned work_degree [NODE_SLOTS];
  logic [9:0]  node_depth [NODE_SLOTS];
  logic [9:0]  order_queue [NODE_SLOTS];
  int unsigned edge_count;
  int unsigned ordered_total;
  bit          sort_valid;
  int unsigned node_setting;

  in_t  pending_items [$];
  out_t expected_results [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          in_taken;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;

  function automatic int unsigned nodes_in_use();
    return (node_setting > NODE_SLOTS) ? NODE_SLOTS : node_setting;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < NODE_SLOTS; i++) begin
      head_valid[i] = 0;
      in_degree[i] = 0;
      node_depth[i] = '0;
    end
    edge_count = 0;
    ordered_total = 0;
    sort_valid = 0;
  endfunction

  // Kahn's algorithm with longest-path depth, walking the out-lists in load order.
  function automatic logic [1:0] sort_graph();
    int unsigned n;
    int unsigned qhead;
    int unsigned qtail;
    int unsigned u;
    int unsigned e;
    int unsigned v;
    logic [9:0] d;
    n = nodes_in_use();
    qhead = 0;
    qtail = 0;
    if (n <= 1) begin
      for (int i = 0; i < n; i++) begin
        order_queue[i] = 10'(i);
        node_depth[i] = '0;
      end
      ordered_total = n;
      sort_valid = 1;
      return ST_OK;
    end
    for (int i = 0; i < n; i++) begin
      work_degree[i] = in_degree[i];
      node_depth[i] = '0;
      if (in_degree[i] == 0) begin
        order_queue[qtail] = 10'(i);
        qtail++;
      end
    end
    while (qhead < qtail) begin
      u = order_queue[qhead];
      qhead++;
      if (head_valid[u]) begin
        e = list_head[u];
        for (int unsigned steps = 0; steps < edge_count && e < EDGE_SLOTS; steps++) begin
          v = edge_target[e];
          if (v < n) begin
            d = (node_depth[u] >= DEPTH_CAP) ? DEPTH_CAP : node_depth[u] + 10'd1;
            if (d > node_depth[v]) node_depth[v] = d;
            if (work_degree[v] > 0) begin
              work_degree[v]--;
              if (work_degree[v] == 0 && qtail < n) begin
                order_queue[qtail] = 10'(v);
                qtail++;
              end
            end
          end
          if (e == list_tail[u]) break;
          e = edge_next[e];
        end
      end
    end
    ordered_total = qhead;
    sort_valid = (qhead >= n);
    return sort_valid ? ST_OK : ST_CYCLE;
  endfunction

  function automatic out_t predict_item(in_t item);
    out_t res;
    int unsigned n;
    res = '0;
    n = nodes_in_use();
    case (item.kind)
      KIND_ADD: begin
        if (item.from_node >= n || item.to_node >= n || edge_count >= EDGE_SLOTS) begin
          res.status = ST_REJECTED;
        end else begin
          edge_target[edge_count] = item.to_node;
          if (head_valid[item.from_node]) begin
            edge_next[list_tail[item.from_node]] = 12'(edge_count);
          end else begin
            list_head[item.from_node] = 12'(edge_count);
            head_valid[item.from_node] = 1;
          end
          list_tail[item.from_node] = 12'(edge_count);
          in_degree[item.to_node]++;
          edge_count++;
          sort_valid = 0;
          res.status = ST_OK;
        end
      end
      KIND_SORT: res.status = sort_graph();
      KIND_READ: begin
        if (sort_valid && item.position < ordered_total) begin
          res.node_index = order_queue[item.position];
          res.depth = node_depth[order_queue[item.position]];
          res.status = ST_OK;
        end else begin
          res.status = ST_NO_SORT;
        end
      end
      default: begin
        clear_graph();
        res.status = ST_OK;
      end
    endcase
    res.sorted_count = ordered_total[10:0];
    return res;
  endfunction

  // Clock generator; the single reset at the start is driven by the main initial block.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    logic nv;
    in_t  nd;
    if (rst_n && (!in_valid || in_taken)) begin
      nv = 1'b0;
      nd = in_data;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        nd = pending_items.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
    in_taken = 0;
  end

  // Receiver stall pattern, whose character is picked anew at random from four modes.
  always @(negedge clk) begin
    if (cycle_count % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (cycle_count % 4 != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(predict_item(in_data));
      in_taken = 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected result transfer: %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Result mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
    end
  end

  task automatic queue_item(logic [1:0] kind, int unsigned from_n, int unsigned to_n,
                            int unsigned pos);
    in_t item;
    item.kind = kind;
    item.from_node = from_n[9:0];
    item.to_node = to_n[9:0];
    item.position = pos[9:0];
    pending_items.push_back(item);
  endtask

  // Wait until every transfer has gone and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Node count changes only once the block has gone quiet, clearing pass included.
  task automatic set_node_count(int unsigned value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[10:0];
    node_setting = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random graph with well-formed loads, a sort and reads, plus some noise.
  task automatic random_graph(int unsigned n);
    int unsigned edges;
    int unsigned a;
    int unsigned b;
    queue_item(KIND_CLEAR, 0, 0, 0);
    edges = $urandom_range(1, 3 * n + 2);
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if ($urandom_range(0, 9) == 0) queue_item(KIND_ADD, $urandom, $urandom, $urandom);
      else if (a < b || $urandom_range(0, 19) == 0) queue_item(KIND_ADD, a, b, $urandom);
      else queue_item(KIND_ADD, b, (a == b) ? n - 1 : a, $urandom);
      if ($urandom_range(0, 15) == 0) queue_item(2'($urandom_range(0, 3)), $urandom,
                                                 $urandom, $urandom);
    end
    queue_item(KIND_SORT, $urandom, $urandom, $urandom);
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 4) == 0) queue_item(KIND_READ, $urandom, $urandom, $urandom);
      else queue_item(KIND_READ, $urandom, $urandom, $urandom_range(0, n));
    end
  endtask

  initial begin
    int unsigned rounds;
    int unsigned pick;
    int unsigned sizes [9] = '{2, 3, 5, 8, 12, 20, 40, 1024, 7};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    cycle_count = 0;
    in_taken = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    node_setting = 0;
    clear_graph();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Small triangle: loads, rejected edges, reads before and after the sort.
    set_node_count(6);
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_ADD, 0, 1, 0);
    queue_item(KIND_ADD, 1, 2, 0);
    queue_item(KIND_ADD, 0, 2, 0);
    queue_item(KIND_ADD, 6, 0, 0);
    queue_item(KIND_ADD, 1023, 1023, 1023);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 5);
    queue_item(KIND_READ, 0, 0, 6);
    queue_item(KIND_READ, 0, 0, 1023);
    // A loop makes the next sort report a cycle.
    queue_item(KIND_ADD, 2, 0, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_CLEAR, 0, 0, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 3);

    // Empty and single-node graphs.
    set_node_count(0);
    queue_item(KIND_ADD, 0, 0, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);
    set_node_count(1);
    queue_item(KIND_ADD, 0, 0, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);

    // Count shrunk after loading leaves edges out of dropped nodes unreleased.
    set_node_count(16);
    queue_item(KIND_CLEAR, 0, 0, 0);
    queue_item(KIND_ADD, 0, 3, 0);
    queue_item(KIND_ADD, 3, 12, 0);
    queue_item(KIND_ADD, 12, 5, 0);
    set_node_count(8);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);

    // A chain inside the full node range.
    set_node_count(1024);
    queue_item(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < 64; i++) queue_item(KIND_ADD, i, i + 1, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 512);
    queue_item(KIND_READ, 0, 0, 1023);

    // Oversized count acts as the full node range.
    set_node_count(2047);
    queue_item(KIND_CLEAR, 0, 0, 0);
    queue_item(KIND_ADD, 1023, 0, 0);
    queue_item(KIND_SORT, 0, 0, 0);
    queue_item(KIND_READ, 0, 0, 1023);

    // Random graphs over a range of node counts.
    rounds = 0;
    pick = 0;
    while (rounds < 320) begin
      set_node_count(sizes[pick]);
      random_graph((sizes[pick] > 64) ? 64 : sizes[pick]);
      rounds += pending_items.size();
      drain();
      pick = (pick + 1) % 9;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
